### src/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/tbeln_pkg.sv
// shared types and constants of the text byte formatter
`default_nettype none

package tbeln_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_NUMBER_ALL       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHOW_ENDS        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHOW_TABS        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

   // character codes
   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_CARET  = 8'd94;
   localparam logic [7:0] CH_DOLLAR = 8'd36;
   localparam logic [7:0] CH_QMARK  = 8'd63;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_DEL    = 8'd127;
   localparam logic [7:0] CTRL_LIMIT  = 8'd32;
   localparam logic [7:0] CTRL_OFFSET = 8'd64;

   localparam int PAD_WIDTH = 6;

   typedef struct packed {
      logic number_all;
      logic number_nonblank;
      logic squeeze_blank;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

   // what the back end has to emit for one request (count travels beside it)
   typedef struct packed {
      logic       number;
      logic       dollar;
      logic       caret;
      logic [7:0] sym;
   } desc_type;

   localparam int DESC_W = $bits(desc_type);

endpackage

`default_nettype wire

### src/tbeln_queue.sv
// two-entry queue between the classifier and the byte sequencer
`default_nettype none
`include "assert_macros.svh"

module tbeln_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_i,
   input  wire logic [DATA_W-1:0] data_i,
   output logic                   full_o,
   input  wire logic              pop_i,
   output logic                   valid_o,
   output logic [DATA_W-1:0]      data_o
);

   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push_i ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_i ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push_i} - {1'b0, pop_i};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         slot_ff[wr_ptr_ff] <= data_i;
      end
   end

   assign full_o  = cnt_ff == 2'd2;
   assign valid_o = cnt_ff != 2'd0;
   assign data_o  = slot_ff[rd_ptr_ff];

   `ASSERT_NEXT(q_push_count, clock, reset, push_i && !pop_i, cnt_ff == $past(cnt_ff) + 2'd1)

endmodule

`default_nettype wire

### src/tbeln_front.sv
// front end: takes input bytes, tracks line state and the bcd count
`default_nettype none

module tbeln_front #(
   parameter int COUNT_DIGITS = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tbeln_pkg::cfg_type          cfg_i,
   input  wire logic                        push_i,
   input  wire logic [7:0]                  byte_i,
   output logic                             full_o,
   input  wire logic                        q_full_i,
   output logic                             q_push_o,
   output logic [4*COUNT_DIGITS-1:0]        q_count_o,
   output tbeln_pkg::desc_type              q_desc_o
);

   localparam int CW = 4 * COUNT_DIGITS;

   logic [CW-1:0] count_ff, count_in;
   logic          prev_nl_ff, prev_nl_in;
   logic          blank_ff, blank_in;
   logic          accept;
   logic          is_nl;
   logic          drop;
   logic          number;
   logic [CW-1:0] count_inc;
   tbeln_pkg::desc_type desc;

   // bcd increment, saturating at all nines
   function automatic logic [CW-1:0] bcd_inc(input logic [CW-1:0] v);
      logic [CW-1:0] r;
      logic          carry;
      r     = v;
      carry = 1'b1;
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (carry) begin
            if (r[4*i +: 4] == 4'd9) begin
               r[4*i +: 4] = 4'd0;
            end else begin
               r[4*i +: 4] = r[4*i +: 4] + 4'd1;
               carry       = 1'b0;
            end
         end
      end
      return carry ? v : r;
   endfunction

   assign full_o = q_full_i;
   assign accept = push_i && !q_full_i;
   assign is_nl  = byte_i == tbeln_pkg::CH_NL;
   assign drop   = cfg_i.squeeze_blank && prev_nl_ff && is_nl && blank_ff;
   assign number = prev_nl_ff &&
                   ((cfg_i.number_all && !cfg_i.number_nonblank) ||
                    (cfg_i.number_nonblank && !is_nl));
   assign count_inc = bcd_inc(count_ff);

   always_comb begin
      desc.number = number;
      desc.dollar = cfg_i.show_ends && is_nl;
      desc.caret  = 1'b0;
      desc.sym    = byte_i;
      if (cfg_i.show_tabs && byte_i == tbeln_pkg::CH_TAB) begin
         desc.caret = 1'b1;
         desc.sym   = tbeln_pkg::CH_TAB + tbeln_pkg::CTRL_OFFSET;
      end else if (cfg_i.show_nonprinting) begin
         if (byte_i < tbeln_pkg::CTRL_LIMIT && byte_i != tbeln_pkg::CH_TAB && !is_nl) begin
            desc.caret = 1'b1;
            desc.sym   = byte_i + tbeln_pkg::CTRL_OFFSET;
         end else if (byte_i == tbeln_pkg::CH_DEL) begin
            desc.caret = 1'b1;
            desc.sym   = tbeln_pkg::CH_QMARK;
         end
      end
   end

   always_comb begin
      count_in   = count_ff;
      prev_nl_in = prev_nl_ff;
      blank_in   = blank_ff;
      if (accept && !drop) begin
         // the final symbol is a newline exactly when the input byte is one
         prev_nl_in = is_nl;
         blank_in   = prev_nl_ff && is_nl;
         if (number) begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         prev_nl_ff <= 1'b1;
         blank_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         prev_nl_ff <= prev_nl_in;
         blank_ff   <= blank_in;
      end
   end

   assign q_push_o  = accept && !drop;
   assign q_count_o = count_in;
   assign q_desc_o  = desc;

endmodule

`default_nettype wire

### src/tbeln_back.sv
// back end: expands one queued request into output bytes
`default_nettype none
`include "assert_macros.svh"

module tbeln_back #(
   parameter int COUNT_DIGITS = 10
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid_i,
   input  wire logic [4*COUNT_DIGITS-1:0]   q_count_i,
   input  wire tbeln_pkg::desc_type         q_desc_i,
   output logic                             q_pop_o,
   output logic                             empty_o,
   input  wire logic                        pop_i,
   output logic [7:0]                       out_byte_o,
   output logic                             last_o
);

   localparam int SIG_W = $clog2(COUNT_DIGITS + 1);
   localparam int POS_W = $clog2(COUNT_DIGITS);

   typedef enum logic [5:0] {
      PH_FIRST  = 6'b000001,
      PH_NUM    = 6'b000010,
      PH_TAB    = 6'b000100,
      PH_DOLLAR = 6'b001000,
      PH_CARET  = 6'b010000,
      PH_SYM    = 6'b100000
   } phase_type;

   phase_type        state_ff, state_in;
   phase_type        cur;
   phase_type        after_tab;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;
   logic             advance;
   logic [SIG_W-1:0] sig;
   logic [SIG_W-1:0] width;
   logic [SIG_W-1:0] idx;
   logic [3:0]       digit;
   logic [7:0]       num_byte;
   logic             num_last;

   // significant digits of the count, at least one
   always_comb begin
      sig = SIG_W'(1);
      for (int i = 0; i < COUNT_DIGITS; i++) begin
         if (q_count_i[4*i +: 4] != 4'd0) begin
            sig = SIG_W'(i + 1);
         end
      end
   end

   assign width    = (sig > SIG_W'(tbeln_pkg::PAD_WIDTH)) ? sig : SIG_W'(tbeln_pkg::PAD_WIDTH);
   assign idx      = width - SIG_W'(1) - SIG_W'(pos_ff);
   assign digit    = q_count_i[4*idx[POS_W-1:0] +: 4];
   assign num_byte = (idx >= sig) ? tbeln_pkg::CH_SPACE : tbeln_pkg::CH_ZERO + {4'd0, digit};
   assign num_last = SIG_W'(pos_ff) == width - SIG_W'(1);

   always_comb begin
      if (q_desc_i.dollar) begin
         after_tab = PH_DOLLAR;
      end else if (q_desc_i.caret) begin
         after_tab = PH_CARET;
      end else begin
         after_tab = PH_SYM;
      end
      if (state_ff == PH_FIRST) begin
         cur = q_desc_i.number ? PH_NUM : after_tab;
      end else begin
         cur = state_ff;
      end
   end

   assign advance = q_valid_i && (!out_valid_ff || pop_i);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !pop_i;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_last_in  = 1'b0;
         case (cur)
            PH_NUM: begin
               out_byte_in = num_byte;
               if (num_last) begin
                  pos_in   = '0;
                  state_in = PH_TAB;
               end else begin
                  pos_in   = pos_ff + POS_W'(1);
                  state_in = PH_NUM;
               end
            end
            PH_TAB: begin
               out_byte_in = tbeln_pkg::CH_TAB;
               state_in    = after_tab;
            end
            PH_DOLLAR: begin
               out_byte_in = tbeln_pkg::CH_DOLLAR;
               state_in    = q_desc_i.caret ? PH_CARET : PH_SYM;
            end
            PH_CARET: begin
               out_byte_in = tbeln_pkg::CH_CARET;
               state_in    = PH_SYM;
            end
            default: begin
               out_byte_in = q_desc_i.sym;
               out_last_in = 1'b1;
               state_in    = PH_FIRST;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PH_FIRST;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign q_pop_o    = advance && cur == PH_SYM;
   assign empty_o    = !out_valid_ff;
   assign out_byte_o = out_byte_ff;
   assign last_o     = out_last_ff;

   `ASSERT_IMPLIES(bk_num_pos, clock, reset, state_ff == PH_NUM, SIG_W'(pos_ff) < width)
   `ASSERT_NEXT(bk_pop_last, clock, reset, q_pop_o, out_valid_ff && out_last_ff)
   `ASSERT_IMPLIES(bk_busy_valid, clock, reset, state_ff != PH_FIRST, q_valid_i)

endmodule

`default_nettype wire

### src/text_byte_escape_line_numberer_unit.sv
// top level of the text byte formatter with line numbers and escapes
`default_nettype none

// Text byte formatter. Takes one text byte per request and produces its output
// bytes (rsp_last marks the final byte of a request): an optional right-aligned
// bcd line number and tab at the start of a line, an optional '$' before a
// newline, caret escapes for tab, control bytes and DEL, and squeezing of
// repeated empty lines (a squeezed newline produces no output bytes at all).
// The front end classifies a request and updates the line state in the cycle
// it is taken; a two-entry queue hands it to the back end, which emits one
// output byte per cycle into an output register while no held byte waits
// for rsp_pop. A request yields one output byte for an ordinary byte, two for
// an escaped byte, and up to max(6, digits) + 3 when a line number is printed.
// The back end's one-byte-per-cycle sequencer sets the unstalled rate; req_full
// rises only when both queue entries are waiting. Configuration registers sit
// at byte addresses 4*i in this order: number_all, number_nonblank,
// squeeze_blank, show_ends, show_tabs, show_nonprinting (bit 0 each); the
// register is picked by address bits 4:2, and writes past the last register
// are ignored and read back zero. COUNT_DIGITS sets the width of the bcd line
// counter, which saturates at all nines.

module text_byte_escape_line_numberer_unit #(
   parameter int COUNT_DIGITS = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request side
   input  wire logic                              req_push,
   input  wire logic [7:0]                        req_in_byte,
   output logic                                   req_full,
   // result side
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [7:0]                             rsp_out_byte,
   output logic                                   rsp_last,
   // configuration port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tbeln_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [tbeln_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tbeln_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                   csr_pready
);

   localparam int CW     = 4 * COUNT_DIGITS;
   localparam int DATA_W = CW + tbeln_pkg::DESC_W;

   tbeln_pkg::cfg_type cfg_ff, cfg_in;
   logic [tbeln_pkg::CSR_IDX_W-1:0] csr_idx;
   logic                            csr_wr;
   logic                            read_bit;

   logic                q_full;
   logic                q_push;
   logic [CW-1:0]       push_count;
   tbeln_pkg::desc_type push_desc;
   logic                q_pop;
   logic                q_valid;
   logic [DATA_W-1:0]   q_head;
   logic [CW-1:0]       head_count;
   tbeln_pkg::desc_type head_desc;

   // configuration registers, one bit each
   assign csr_idx    = csr_paddr[tbeln_pkg::CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            tbeln_pkg::REG_NUMBER_ALL:       cfg_in.number_all       = csr_pwdata[0];
            tbeln_pkg::REG_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_pwdata[0];
            tbeln_pkg::REG_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_pwdata[0];
            tbeln_pkg::REG_SHOW_ENDS:        cfg_in.show_ends        = csr_pwdata[0];
            tbeln_pkg::REG_SHOW_TABS:        cfg_in.show_tabs        = csr_pwdata[0];
            tbeln_pkg::REG_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_pwdata[0];
            default: ; // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         tbeln_pkg::REG_NUMBER_ALL:       read_bit = cfg_ff.number_all;
         tbeln_pkg::REG_NUMBER_NONBLANK:  read_bit = cfg_ff.number_nonblank;
         tbeln_pkg::REG_SQUEEZE_BLANK:    read_bit = cfg_ff.squeeze_blank;
         tbeln_pkg::REG_SHOW_ENDS:        read_bit = cfg_ff.show_ends;
         tbeln_pkg::REG_SHOW_TABS:        read_bit = cfg_ff.show_tabs;
         tbeln_pkg::REG_SHOW_NONPRINTING: read_bit = cfg_ff.show_nonprinting;
         default:                         read_bit = 1'b0;
      endcase
   end

   assign csr_prdata = {{(tbeln_pkg::CSR_DATA_W-1){1'b0}}, read_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: classify each request, keep line state and count
   tbeln_front #(
      .COUNT_DIGITS (COUNT_DIGITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg_i     (cfg_ff),
      .push_i    (req_push),
      .byte_i    (req_in_byte),
      .full_o    (req_full),
      .q_full_i  (q_full),
      .q_push_o  (q_push),
      .q_count_o (push_count),
      .q_desc_o  (push_desc)
   );

   // queue carries the count snapshot beside the request descriptor
   tbeln_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (q_push),
      .data_i  ({push_count, push_desc}),
      .full_o  (q_full),
      .pop_i   (q_pop),
      .valid_o (q_valid),
      .data_o  (q_head)
   );

   assign head_count = q_head[DATA_W-1 -: CW];
   assign head_desc  = tbeln_pkg::desc_type'(q_head[tbeln_pkg::DESC_W-1:0]);

   // back end: one output byte per cycle unless a held output byte is not popped
   tbeln_back #(
      .COUNT_DIGITS (COUNT_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid_i  (q_valid),
      .q_count_i  (head_count),
      .q_desc_i   (head_desc),
      .q_pop_o    (q_pop),
      .empty_o    (rsp_empty),
      .pop_i      (rsp_pop),
      .out_byte_o (rsp_out_byte),
      .last_o     (rsp_last)
   );

endmodule

`default_nettype wire
